### design/kvx_pkg.sv
// Shared types and constants for the key line value extractor.
// Used by kvx_step, kvx_res_fifo and key_line_value_extractor_core.
package kvx_pkg;

  typedef enum logic [2:0] {
    PH_KEY    = 3'd0,
    PH_SPACES = 3'd1,
    PH_SKIP   = 3'd2,
    PH_LEAD   = 3'd3,
    PH_VALUE  = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  localparam logic [1:0] ST_CHAR = 2'd0;
  localparam logic [1:0] ST_END  = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;

  localparam logic [2:0] CFG_KEY_LENGTH = 3'd0;
  localparam logic [2:0] CFG_KEY_A      = 3'd1;
  localparam logic [2:0] CFG_KEY_B      = 3'd2;
  localparam logic [2:0] CFG_KEY_C      = 3'd3;
  localparam logic [2:0] CFG_KEY_D      = 3'd4;

  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    phase_t     phase;
    logic [5:0] key_index;
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } step_t;

endpackage

### design/kvx_step.sv
// Combinational next-state and result logic for one dictionary byte.
// Depends on kvx_pkg.
module kvx_step (
  input  kvx_pkg::phase_t phase_i,
  input  logic [5:0]      key_index_i,
  input  logic [5:0]      key_len_i,
  input  logic [255:0]    key_bits_i,
  input  logic [7:0]      char_i,
  input  logic            last_i,
  output kvx_pkg::step_t  step_o
);

  kvx_pkg::phase_t ph;
  logic [5:0]      idx;
  logic [7:0]      kc;
  logic            zero;
  logic            a_v;
  logic            e_v;
  kvx_pkg::res_t   a;
  kvx_pkg::res_t   e;

  assign zero = (char_i == 8'd0);
  assign kc   = key_bits_i[{key_index_i[4:0], 3'b000} +: 8];

  always_comb begin
    ph  = phase_i;
    idx = key_index_i;
    a_v = 1'b0;
    a   = '0;
    e_v = 1'b0;
    e   = '0;
    // A key index already at the length counts as a finished key match.
    if (ph == kvx_pkg::PH_KEY && idx >= key_len_i) begin
      ph = kvx_pkg::PH_SPACES;
    end
    if (!zero) begin
      unique case (ph)
        kvx_pkg::PH_KEY: begin
          if (char_i == kc) begin
            idx = idx + 6'd1;
            if (idx >= key_len_i) begin
              ph = kvx_pkg::PH_SPACES;
            end
          end else if (char_i == kvx_pkg::CH_NL) begin
            idx = '0;
          end else begin
            ph = kvx_pkg::PH_SKIP;
          end
        end
        kvx_pkg::PH_SPACES: begin
          if (char_i == kvx_pkg::CH_COLON) begin
            ph = kvx_pkg::PH_LEAD;
          end else if (char_i == kvx_pkg::CH_NL) begin
            ph  = kvx_pkg::PH_KEY;
            idx = '0;
          end else if (char_i != kvx_pkg::CH_SPACE) begin
            ph = kvx_pkg::PH_SKIP;
          end
        end
        kvx_pkg::PH_SKIP: begin
          if (char_i == kvx_pkg::CH_NL) begin
            ph  = kvx_pkg::PH_KEY;
            idx = '0;
          end
        end
        kvx_pkg::PH_LEAD, kvx_pkg::PH_VALUE: begin
          if (char_i == kvx_pkg::CH_NL) begin
            a_v = 1'b1;
            a   = '{ch: kvx_pkg::CH_SPACE, status: kvx_pkg::ST_END};
            ph  = kvx_pkg::PH_DONE;
          end else if (ph == kvx_pkg::PH_VALUE || char_i != kvx_pkg::CH_SPACE) begin
            a_v = 1'b1;
            a   = '{ch: char_i, status: kvx_pkg::ST_CHAR};
            ph  = kvx_pkg::PH_VALUE;
          end
        end
        default: begin
        end
      endcase
    end
    if (zero || last_i) begin
      if (ph == kvx_pkg::PH_LEAD || ph == kvx_pkg::PH_VALUE) begin
        e_v = 1'b1;
        e   = '{ch: kvx_pkg::CH_SPACE, status: kvx_pkg::ST_END};
      end else if (ph != kvx_pkg::PH_DONE) begin
        e_v = 1'b1;
        e   = '{ch: 8'd0, status: kvx_pkg::ST_NONE};
      end
      ph  = kvx_pkg::PH_KEY;
      idx = '0;
    end
  end

  always_comb begin
    step_o.phase     = ph;
    step_o.key_index = idx;
    if (a_v) begin
      step_o.r0    = a;
      step_o.r1    = e;
      step_o.count = e_v ? 2'd2 : 2'd1;
    end else begin
      step_o.r0    = e;
      step_o.r1    = '0;
      step_o.count = e_v ? 2'd1 : 2'd0;
    end
  end

endmodule

### design/kvx_res_fifo.sv
// Four-entry result queue that takes up to two items a cycle and gives one.
// Depends on kvx_pkg.
module kvx_res_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_n,
  input  kvx_pkg::res_t push0,
  input  kvx_pkg::res_t push1,
  input  logic          pop,
  output logic [2:0]    count,
  output kvx_pkg::res_t head
);

  kvx_pkg::res_t mem_r [4];
  logic [1:0]    wr_r, wr_nxt;
  logic [1:0]    rd_r, rd_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic [1:0]    wr1;

  assign wr1     = wr_r + 2'd1;
  assign wr_nxt  = wr_r + push_n;
  assign rd_nxt  = rd_r + {1'b0, pop};
  assign cnt_nxt = cnt_r + {1'b0, push_n} - {2'b00, pop};
  assign count   = cnt_r;
  assign head    = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr1] <= push1;
    end
  end

endmodule

### design/key_line_value_extractor_core.sv
// Key line value extractor: top level with input register, step logic and result queue.
// Depends on kvx_pkg, kvx_step and kvx_res_fifo.
//
// The block takes one dictionary byte per item and finds the first line that
// begins with the configured key, optional spaces and a colon. It then emits
// the value bytes of that line (status 0), skipping spaces after the colon,
// and a closing space (status 1). A buffer that ends without a match yields
// one item with status 2. A buffer ends at a zero byte or an item with tlast.
// Each byte is held in an input register and processed once the result queue has
// room for two results, which then pass through the queue to the output. The block
// sustains one byte per cycle, and stalls its input only while the four-entry result
// queue holds more than two items, which a byte that yields two results can cause.
module key_line_value_extractor_core #(
  parameter int MAX_KEY_LEN = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_char
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_char
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [5:0]      key_length_r;
  logic [255:0]    key_bits_r;
  logic [5:0]      eff_len;
  kvx_pkg::phase_t phase_r;
  logic [5:0]      key_index_r;
  logic            item_v_r;
  logic [7:0]      char_r;
  logic            last_r;
  logic            proc;
  logic            take;
  logic [2:0]      q_count;
  logic [1:0]      push_n;
  kvx_pkg::res_t   head;
  kvx_pkg::step_t  step;

  assign eff_len = (key_length_r > 6'(MAX_KEY_LEN)) ? 6'(MAX_KEY_LEN) : key_length_r;

  // The held byte is processed once the queue has room for two results.
  assign proc      = item_v_r && (q_count <= 3'd2);
  assign in_tready = !item_v_r || proc;
  assign take      = in_tvalid && in_tready;
  assign push_n    = proc ? step.count : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= '0;
      key_bits_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        kvx_pkg::CFG_KEY_LENGTH: key_length_r <= cfg_wdata[5:0];
        kvx_pkg::CFG_KEY_A:      key_bits_r[63:0]    <= cfg_wdata;
        kvx_pkg::CFG_KEY_B:      key_bits_r[127:64]  <= cfg_wdata;
        kvx_pkg::CFG_KEY_C:      key_bits_r[191:128] <= cfg_wdata;
        kvx_pkg::CFG_KEY_D:      key_bits_r[255:192] <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r    <= 1'b0;
      phase_r     <= kvx_pkg::PH_KEY;
      key_index_r <= '0;
    end else begin
      if (take) begin
        item_v_r <= 1'b1;
      end else if (proc) begin
        item_v_r <= 1'b0;
      end
      if (proc) begin
        phase_r     <= step.phase;
        key_index_r <= step.key_index;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      char_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  kvx_step u_step (
    .phase_i     (phase_r),
    .key_index_i (key_index_r),
    .key_len_i   (eff_len),
    .key_bits_i  (key_bits_r),
    .char_i      (char_r),
    .last_i      (last_r),
    .step_o      (step)
  );

  kvx_res_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_n (push_n),
    .push0  (step.r0),
    .push1  (step.r1),
    .pop    (out_tvalid && out_tready),
    .count  (q_count),
    .head   (head)
  );

  assign out_tvalid = (q_count != 3'd0);
  assign out_tdata  = head.ch;
  assign out_tuser  = head.status;

endmodule
